FILE: rtl/sandpile_grain_drop_top_defines.svh
// Assertion macros shared by the sandpile checker.
`ifndef SANDPILE_GRAIN_DROP_TOP_DEFINES_SVH
`define SANDPILE_GRAIN_DROP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SGD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sandpile check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SGD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sandpile check failed");

`endif

FILE: rtl/sgd_pkg.sv
// Shared constants for the sandpile grain-drop block.
package sgd_pkg;

    // Default grid bounds handed to the top level
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Cell storage: a settled cell holds 0..3, a cell mid-avalanche up to 7
    localparam int CELL_W     = 3;
    localparam int RES_W      = 2;
    localparam int STABLE_MAX = 3;
    localparam int TOPPLE_N   = 4;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;
    localparam logic [CFG_W-1:0]     GRID_RESET = 7'd64;

    // Input fields
    localparam int OP_W  = 2;
    localparam int POS_W = 7;
    localparam logic [OP_W-1:0] OP_DROP  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

endpackage

FILE: rtl/sandpile_grain_drop_top.sv
// Sandpile grid: drop, write and read of cells with full avalanche settling.
//
// Input channel (i_in_valid / o_in_stall) carries one op per beat: drop a
// grain, write a cell or read a cell at (row, col). Output channel
// (o_out_valid / i_out_stall) returns one beat per op: the settled value of
// the target cell and an outside flag. Ops are handled one at a time.
// An outside target goes from the idle state straight to the done state;
// read, write and a drop that causes no topple pass through the target
// state first. A toppling drop runs full raster sweeps of the grid in use
// until one sweep finds no unstable cell: each topple writes the shed cell
// and then bumps each in-bounds neighbor in turn; the target is then re-read.
// The sweep rate is set by the single read and single write port of the
// cell store, one cell touched per cycle.
// Reset: grid size returns to 64 x 64 and a clearing pass writes zero to
// every store entry; o_in_stall stays high until it ends. Configuration
// writes are taken at any time.
// A stalled output holds its beat; the finished result waits in the
// sequencer until the output register frees.
module sandpile_grain_drop_top #(
    parameter int MAX_ROWS = sgd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = sgd_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [sgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sgd_pkg::CFG_W-1:0]      i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sgd_pkg::OP_W-1:0]       i_op,
    input  logic [sgd_pkg::POS_W-1:0]      i_row,
    input  logic [sgd_pkg::POS_W-1:0]      i_col,
    input  logic [sgd_pkg::RES_W-1:0]      i_write_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sgd_pkg::RES_W-1:0]      o_cell_value,
    output logic                           o_was_outside
);
    import sgd_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW  = RW + CW;
    localparam int RN  = $clog2(MAX_ROWS + 1);
    localparam int CN  = $clog2(MAX_COLS + 1);
    localparam int UWR = (RN > POS_W) ? RN : POS_W;
    localparam int UWC = (CN > POS_W) ? CN : POS_W;

    // neighbor slots
    localparam int NB_UP    = 0;
    localparam int NB_DOWN  = 1;
    localparam int NB_LEFT  = 2;
    localparam int NB_RIGHT = 3;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_TGT      = 9'b000000100,
        ST_SCAN_RD  = 9'b000001000,
        ST_SCAN_CHK = 9'b000010000,
        ST_NB_WR    = 9'b000100000,
        ST_FIN_RD   = 9'b001000000,
        ST_FIN_DATA = 9'b010000000,
        ST_DONE     = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [OP_W-1:0]   r_op, n_op;
    logic [RES_W-1:0]  r_wv, n_wv;
    logic [AW-1:0]     r_tgt, n_tgt;
    logic [RW-1:0]     r_r, n_r;
    logic [CW-1:0]     r_c, n_c;
    logic              r_unstable, n_unstable;
    logic [3:0]        r_nb_mask, n_nb_mask;
    logic [AW-1:0]     r_nb_addr, n_nb_addr;
    logic [RES_W-1:0]  r_res_val, n_res_val;
    logic              r_res_out, n_res_out;
    logic              r_out_valid, n_out_valid;
    logic [RES_W-1:0]  r_out_val, n_out_val;
    logic              r_out_out, n_out_out;
    logic [CFG_W-1:0]  r_grid_rows, r_grid_cols;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_wa, ram_ra;
    logic [CELL_W-1:0] ram_wd, ram_rd;

    logic [UWR-1:0]    used_rows, row_ext;
    logic [UWC-1:0]    used_cols, col_ext;
    logic              in_outside;
    logic [AW-1:0]     in_addr;
    logic              row_last, col_last, sweep_end;
    logic [RW-1:0]     next_r;
    logic [CW-1:0]     next_c;
    logic [AW-1:0]     nb_addr [4];
    logic [3:0]        topple_mask, pick_mask;
    logic [1:0]        pick_sel;
    logic [CELL_W-1:0] bumped;

    // cell store
    sgd_cell_ram #(
        .AW (AW),
        .DW (CELL_W)
    ) u_sgd_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // grid in use, clamped to the storage bounds
    assign used_rows = (UWR'(r_grid_rows) > UWR'(MAX_ROWS)) ? UWR'(MAX_ROWS)
                                                          : UWR'(r_grid_rows);
    assign used_cols = (UWC'(r_grid_cols) > UWC'(MAX_COLS)) ? UWC'(MAX_COLS)
                                                          : UWC'(r_grid_cols);

    // target decode
    assign row_ext    = UWR'(i_row);
    assign col_ext    = UWC'(i_col);
    assign in_outside = (row_ext >= used_rows) || (col_ext >= used_cols);
    assign in_addr    = {row_ext[RW-1:0], col_ext[CW-1:0]};

    // raster position bookkeeping
    assign row_last  = (UWR'(r_r) + UWR'(1)) == used_rows;
    assign col_last  = (UWC'(r_c) + UWC'(1)) == used_cols;
    assign sweep_end = row_last && col_last;
    assign next_c    = col_last ? '0 : r_c + CW'(1);
    assign next_r    = col_last ? r_r + RW'(1) : r_r;

    // neighbors of the current cell
    assign nb_addr[NB_UP]    = {r_r - RW'(1), r_c};
    assign nb_addr[NB_DOWN]  = {r_r + RW'(1), r_c};
    assign nb_addr[NB_LEFT]  = {r_r, r_c - CW'(1)};
    assign nb_addr[NB_RIGHT] = {r_r, r_c + CW'(1)};

    assign topple_mask[NB_UP]    = (r_r != '0);
    assign topple_mask[NB_DOWN]  = !row_last;
    assign topple_mask[NB_LEFT]  = (r_c != '0);
    assign topple_mask[NB_RIGHT] = !col_last;

    // lowest pending neighbor
    assign pick_mask = (r_state == ST_NB_WR) ? r_nb_mask : topple_mask;
    always_comb begin
        pick_sel = '0;
        for (int k = 3; k >= 0; k--) begin
            if (pick_mask[k]) begin
                pick_sel = 2'(k);
            end
        end
    end

    assign bumped = ram_rd + CELL_W'(1);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_wv        = r_wv;
        n_tgt       = r_tgt;
        n_r         = r_r;
        n_c         = r_c;
        n_unstable  = r_unstable;
        n_nb_mask   = r_nb_mask;
        n_nb_addr   = r_nb_addr;
        n_res_val   = r_res_val;
        n_res_out   = r_res_out;
        ram_we      = 1'b0;
        ram_wa      = r_tgt;
        ram_wd      = '0;
        ram_re      = 1'b0;
        ram_ra      = r_tgt;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_wa = r_clr;
                n_clr  = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_op;
                    n_wv  = i_write_value;
                    n_tgt = in_addr;
                    if (in_outside) begin
                        n_res_val = '0;
                        n_res_out = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        ram_re  = 1'b1;
                        ram_ra  = in_addr;
                        n_state = ST_TGT;
                    end
                end
            end
            ST_TGT: begin
                n_res_out = 1'b0;
                case (r_op)
                    OP_DROP: begin
                        ram_we = 1'b1;
                        ram_wd = bumped;
                        if (bumped > CELL_W'(STABLE_MAX)) begin
                            n_r        = '0;
                            n_c        = '0;
                            n_unstable = 1'b0;
                            n_state    = ST_SCAN_RD;
                        end else begin
                            n_res_val = bumped[RES_W-1:0];
                            n_state   = ST_DONE;
                        end
                    end
                    OP_WRITE: begin
                        ram_we    = 1'b1;
                        ram_wd    = CELL_W'(r_wv);
                        n_res_val = r_wv;
                        n_state   = ST_DONE;
                    end
                    default: begin
                        n_res_val = ram_rd[RES_W-1:0];
                        n_state   = ST_DONE;
                    end
                endcase
            end
            ST_SCAN_RD: begin
                ram_re  = 1'b1;
                ram_ra  = {r_r, r_c};
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (ram_rd > CELL_W'(STABLE_MAX)) begin
                    // topple: shed four grains, then feed the neighbors
                    ram_we     = 1'b1;
                    ram_wa     = {r_r, r_c};
                    ram_wd     = ram_rd - CELL_W'(TOPPLE_N);
                    n_unstable = 1'b1;
                    if (topple_mask != '0) begin
                        ram_re    = 1'b1;
                        ram_ra    = nb_addr[pick_sel];
                        n_nb_addr = nb_addr[pick_sel];
                        n_nb_mask = topple_mask & ~(4'b0001 << pick_sel);
                        n_state   = ST_NB_WR;
                    end else if (sweep_end) begin
                        n_r        = '0;
                        n_c        = '0;
                        n_unstable = 1'b0;
                        n_state    = ST_SCAN_RD;
                    end else begin
                        n_r     = next_r;
                        n_c     = next_c;
                        n_state = ST_SCAN_RD;
                    end
                end else if (sweep_end) begin
                    if (r_unstable) begin
                        n_r        = '0;
                        n_c        = '0;
                        n_unstable = 1'b0;
                        n_state    = ST_SCAN_RD;
                    end else begin
                        n_state = ST_FIN_RD;
                    end
                end else begin
                    // stable: stream straight on to the next cell
                    n_r    = next_r;
                    n_c    = next_c;
                    ram_re = 1'b1;
                    ram_ra = {next_r, next_c};
                end
            end
            ST_NB_WR: begin
                ram_we = 1'b1;
                ram_wa = r_nb_addr;
                ram_wd = bumped;
                if (r_nb_mask != '0) begin
                    ram_re    = 1'b1;
                    ram_ra    = nb_addr[pick_sel];
                    n_nb_addr = nb_addr[pick_sel];
                    n_nb_mask = r_nb_mask & ~(4'b0001 << pick_sel);
                end else if (sweep_end) begin
                    // a topple happened this sweep, so run another one
                    n_r        = '0;
                    n_c        = '0;
                    n_unstable = 1'b0;
                    n_state    = ST_SCAN_RD;
                end else begin
                    n_r     = next_r;
                    n_c     = next_c;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_FIN_RD: begin
                ram_re  = 1'b1;
                ram_ra  = r_tgt;
                n_state = ST_FIN_DATA;
            end
            ST_FIN_DATA: begin
                n_res_val = ram_rd[RES_W-1:0];
                n_res_out = 1'b0;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_out   = r_out_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
            n_out_valid = 1'b1;
            n_out_val   = r_res_val;
            n_out_out   = r_res_out;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_unstable  <= 1'b0;
            r_out_valid <= 1'b0;
            r_grid_rows <= GRID_RESET;
            r_grid_cols <= GRID_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_unstable  <= n_unstable;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_grid_rows <= i_cfg_data;
                    CFG_COLS: r_grid_cols <= i_cfg_data;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_wv      <= n_wv;
        r_tgt     <= n_tgt;
        r_r       <= n_r;
        r_c       <= n_c;
        r_nb_mask <= n_nb_mask;
        r_nb_addr <= n_nb_addr;
        r_res_val <= n_res_val;
        r_res_out <= n_res_out;
        r_out_val <= n_out_val;
        r_out_out <= n_out_out;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cell_value  = r_out_val;
    assign o_was_outside = r_out_out;

endmodule

FILE: rtl/sgd_cell_ram.sv
// Simple dual-port cell store: one write port, one registered read port.
module sgd_cell_ram #(
    parameter int AW = 12,
    parameter int DW = sgd_pkg::CELL_W
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    import sgd_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sgd_checker.sv
// Port-level checks for the sandpile block, bound to the top level.
`include "sandpile_grain_drop_top_defines.svh"

module sgd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [sgd_pkg::RES_W-1:0] o_cell_value,
    input logic                      o_was_outside
);
    import sgd_pkg::*;

    // an ignored target always reports an empty cell
    `SGD_ASSERT_IMP(a_outside_zero, o_out_valid && o_was_outside, o_cell_value == '0)

    // one op in flight: the beat after an accept is stalled
    `SGD_ASSERT_NXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)

    // a result only appears while an op was being worked on
    `SGD_ASSERT_IMP(a_out_after_work, $rose(o_out_valid), $past(o_in_stall))

    // stalled output beat holds
    `SGD_ASSERT_NXT(a_out_hold_valid, o_out_valid && i_out_stall, o_out_valid)
    `SGD_ASSERT_NXT(a_out_hold_data, o_out_valid && i_out_stall,
                    $stable(o_cell_value) && $stable(o_was_outside))

endmodule

bind sandpile_grain_drop_top sgd_checker u_sgd_checker (.*);
